[design/grid_dda_column_raycaster_defines.svh]
// Assertion macros used by the raycaster design.
`ifndef GRID_DDA_COLUMN_RAYCASTER_DEFINES_SVH
`define GRID_DDA_COLUMN_RAYCASTER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only outside of reset.
`define GDDA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define GDDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GDDA_ASSERT(lbl, clk, rstn, prop, msg)
`define GDDA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/gdda_pkg.sv]
package gdda_pkg;

    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 512;
    localparam int HALF_H        = SCREEN_HEIGHT / 2;
    localparam int GRID_SIZE     = 64;
    localparam int GRID_AW       = $clog2(GRID_SIZE);
    localparam int MAP_DEPTH     = GRID_SIZE * GRID_SIZE;
    localparam int MAP_AW        = $clog2(MAP_DEPTH);
    localparam int TEXTURE_SIZE  = 64;
    localparam int TEX_BITS      = $clog2(TEXTURE_SIZE);
    // Camera value is col * 2^17 / SCREEN_WIDTH, a plain shift.
    localparam int CAM_SHIFT     = 17 - $clog2(SCREEN_WIDTH);

    localparam logic [32:0] DELTA_NUM = 33'h1_0000_0000;
    localparam logic [32:0] LH_NUM    = 33'(SCREEN_HEIGHT) << 16;
    localparam logic [32:0] STEP_NUM  = 33'(TEXTURE_SIZE) << 16;
    localparam logic [22:0] OUT_SAT   = 23'h40_0000;
    localparam logic [31:0] DIST_MAX  = 32'hFFFF_FFFF;
    localparam logic [5:0]  DIV_STEPS = 6'd33;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [1:0] TEX_NORTH = 2'd0;
    localparam logic [1:0] TEX_SOUTH = 2'd1;
    localparam logic [1:0] TEX_WEST  = 2'd2;
    localparam logic [1:0] TEX_EAST  = 2'd3;

    localparam logic [2:0] CFG_POS_X   = 3'd0;
    localparam logic [2:0] CFG_POS_Y   = 3'd1;
    localparam logic [2:0] CFG_DIR_X   = 3'd2;
    localparam logic [2:0] CFG_DIR_Y   = 3'd3;
    localparam logic [2:0] CFG_PLANE_X = 3'd4;
    localparam logic [2:0] CFG_PLANE_Y = 3'd5;
    localparam logic [2:0] CFG_GRID_W  = 3'd6;
    localparam logic [2:0] CFG_GRID_H  = 3'd7;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_RAYX,
        S_RAYY,
        S_RAYD,
        S_DIVX,
        S_DIVY,
        S_SIDEX,
        S_SIDEY,
        S_SIDED,
        S_WSTEP,
        S_WREAD,
        S_DIVLH,
        S_DIVST,
        S_WALL,
        S_TSTART,
        S_TSTARTD,
        S_DONE
    } t_state;

endpackage

[design/gdda_ram.sv]
module gdda_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/grid_dda_column_raycaster.sv]
// Channel   Valid        Stall         Payload
// input     i_in_valid   o_in_stall    i_op, i_screen_column, i_cell_row, i_cell_col,
//                                      i_cell_is_wall
// output    o_out_valid  i_out_stall   o_column_out .. o_texture_start
// config    i_cfg_we     (none)        i_cfg_index, i_cfg_data
//
// A cell write is done in the idle state when accepted. A cast runs four
// 33-step divisions on the shared restoring divider, uses the shared multiplier
// for the ray, side-distance and texture products, and takes a step state and
// a read state per DDA step for the map memory read.
// After reset all 4096 map cells are cleared, one cell a cycle, with input stalled.
// A finished result waits in the output register; the next cast may run meanwhile.
`include "grid_dda_column_raycaster_defines.svh"

module grid_dda_column_raycaster
    import gdda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [9:0]  i_screen_column,
    input  logic [5:0]  i_cell_row,
    input  logic [5:0]  i_cell_col,
    input  logic        i_cell_is_wall,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_column_out,
    output logic        o_hit_side,
    output logic [1:0]  o_texture_index,
    output logic [5:0]  o_texture_column,
    output logic [15:0] o_line_height,
    output logic [8:0]  o_draw_start,
    output logic [8:0]  o_draw_end,
    output logic [22:0] o_texture_step,
    output logic [22:0] o_texture_start,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [21:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [21:0] r_pos_x, r_pos_y;
    logic [17:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [6:0]  r_grid_w, r_grid_h;

    logic [MAP_AW-1:0] r_clr_addr;
    logic [9:0]  r_col;
    logic [18:0] r_rx, r_ry;
    logic [31:0] r_dx, r_dy, r_sx, r_sy, r_perp;
    logic [7:0]  r_mx, r_my;
    logic        r_side;
    logic [15:0] r_lh;
    logic [22:0] r_step, r_tstart;
    logic [5:0]  r_tex;

    logic [31:0] r_div_rem, r_div_d;
    logic [32:0] r_div_quo;
    logic [5:0]  r_div_cnt;

    logic signed [32:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [51:0] r_prod;

    logic              ram_we, ram_wdata, ram_rdata;
    logic [MAP_AW-1:0] ram_waddr, ram_raddr;

    logic        r_out_valid;
    logic [9:0]  r_out_col;
    logic        r_out_side;
    logic [1:0]  r_out_tidx;
    logic [5:0]  r_out_tex;
    logic [15:0] r_out_lh;
    logic [8:0]  r_out_ds, r_out_de;
    logic [22:0] r_out_step, r_out_tstart;

    logic        in_accept, out_free, in_stall;
    logic        div_load;
    logic [31:0] div_load_d;
    logic [32:0] div_load_n;

    // ---------------- combinational datapath ----------------
    logic [17:0] cam_u, cam;
    logic [18:0] abs_rx, abs_ry;
    logic [16:0] fx_term, fy_term;
    logic [32:0] div_sh;
    logic        div_ge;
    logic [32:0] div_diff;
    logic [31:0] div_q_sat;
    logic [15:0] lh_next;
    logic [22:0] step_next;
    logic        step_x;
    logic [32:0] sx_add, sy_add;
    logic [7:0]  mx_next, my_next;
    logic [6:0]  w_eff, h_eff;
    logic        out_of_map, walk_stop;
    logic [31:0] perp_now;
    logic [14:0] lh_half, off;
    logic [8:0]  ds, de;
    logic [15:0] frac;
    logic [5:0]  tex_raw;
    logic        rx_pos, ry_pos, mirror;
    logic [1:0]  tidx;

    assign cam_u  = 18'(r_col) << CAM_SHIFT;
    assign cam    = cam_u - 18'd65536;
    assign abs_rx = r_rx[18] ? (19'd0 - r_rx) : r_rx;
    assign abs_ry = r_ry[18] ? (19'd0 - r_ry) : r_ry;
    assign fx_term = r_rx[18] ? {1'b0, r_pos_x[15:0]} : (17'h10000 - {1'b0, r_pos_x[15:0]});
    assign fy_term = r_ry[18] ? {1'b0, r_pos_y[15:0]} : (17'h10000 - {1'b0, r_pos_y[15:0]});

    assign div_sh    = {r_div_rem, r_div_quo[32]};
    assign div_ge    = div_sh >= {1'b0, r_div_d};
    assign div_diff  = div_sh - {1'b0, r_div_d};
    assign div_q_sat = r_div_quo[32] ? DIST_MAX : r_div_quo[31:0];
    assign lh_next   = (|r_div_quo[32:16]) ? 16'hFFFF : r_div_quo[15:0];
    assign step_next = (r_div_quo > 33'(OUT_SAT)) ? OUT_SAT : r_div_quo[22:0];

    // Ties step in y.
    assign step_x  = r_sx < r_sy;
    assign sx_add  = {1'b0, r_sx} + {1'b0, r_dx};
    assign sy_add  = {1'b0, r_sy} + {1'b0, r_dy};
    assign mx_next = r_mx + (r_rx[18] ? 8'hFF : 8'h01);
    assign my_next = r_my + (r_ry[18] ? 8'hFF : 8'h01);
    assign w_eff   = (r_grid_w > 7'(GRID_SIZE)) ? 7'(GRID_SIZE) : r_grid_w;
    assign h_eff   = (r_grid_h > 7'(GRID_SIZE)) ? 7'(GRID_SIZE) : r_grid_h;
    assign out_of_map = r_mx[7] || (r_mx >= {1'b0, w_eff})
                     || r_my[7] || (r_my >= {1'b0, h_eff});
    assign walk_stop  = out_of_map || ram_rdata;
    assign perp_now   = r_side ? (r_sy - r_dy) : (r_sx - r_dx);

    assign lh_half = r_lh[15:1];
    assign off = (lh_half > 15'(HALF_H)) ? (lh_half - 15'(HALF_H)) : 15'd0;
    assign ds  = (lh_half >= 15'(HALF_H)) ? 9'd0 : 9'(15'(HALF_H) - lh_half);
    assign de  = (lh_half >= 15'(HALF_H)) ? 9'(SCREEN_HEIGHT - 1)
                                          : 9'(lh_half + 15'(HALF_H));

    // Only the low 16 bits of the hit coordinate matter; the low product bits
    // already equal those of the floored shift.
    assign frac    = (r_side ? r_pos_x[15:0] : r_pos_y[15:0]) + r_prod[31:16];
    assign tex_raw = frac[15:16-TEX_BITS];
    assign rx_pos  = !r_rx[18] && (r_rx != 19'd0);
    assign ry_pos  = !r_ry[18] && (r_ry != 19'd0);
    assign mirror  = (!r_side && rx_pos) || (r_side && r_ry[18]);
    assign tidx    = r_side ? (ry_pos ? TEX_SOUTH : TEX_NORTH)
                            : (rx_pos ? TEX_EAST : TEX_WEST);

    assign in_accept = i_in_valid && !in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (r_clr_addr == MAP_AW'(MAP_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:    if (in_accept && i_op == OP_CAST) n_state = S_RAYX;
            S_RAYX:    n_state = S_RAYY;
            S_RAYY:    n_state = S_RAYD;
            S_RAYD:    n_state = S_DIVX;
            S_DIVX:    if (r_div_cnt == 6'd0) n_state = S_DIVY;
            S_DIVY:    if (r_div_cnt == 6'd0) n_state = S_SIDEX;
            S_SIDEX:   n_state = S_SIDEY;
            S_SIDEY:   n_state = S_SIDED;
            S_SIDED:   n_state = S_WSTEP;
            S_WSTEP:   n_state = S_WREAD;
            S_WREAD:   n_state = walk_stop ? S_DIVLH : S_WSTEP;
            S_DIVLH:   if (r_div_cnt == 6'd0) n_state = S_DIVST;
            S_DIVST:   if (r_div_cnt == 6'd0) n_state = S_WALL;
            S_WALL:    n_state = S_TSTART;
            S_TSTART:  n_state = S_TSTARTD;
            S_TSTARTD: n_state = S_DONE;
            S_DONE:    if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        in_stall   = 1'b1;
        mul_a      = '0;
        mul_b      = '0;
        div_load   = 1'b0;
        div_load_d = '0;
        div_load_n = '0;
        ram_we     = 1'b0;
        ram_waddr  = {i_cell_row, i_cell_col};
        ram_wdata  = i_cell_is_wall;
        ram_raddr  = step_x ? {r_my[GRID_AW-1:0], mx_next[GRID_AW-1:0]}
                            : {my_next[GRID_AW-1:0], r_mx[GRID_AW-1:0]};
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = 1'b0;
            end
            S_IDLE: begin
                in_stall = 1'b0;
                ram_we   = in_accept && (i_op == OP_WRITE);
            end
            S_RAYX: begin
                mul_a = {{15{r_plane_x[17]}}, r_plane_x};
                mul_b = {cam[17], cam};
            end
            S_RAYY: begin
                mul_a = {{15{r_plane_y[17]}}, r_plane_y};
                mul_b = {cam[17], cam};
            end
            S_RAYD: begin
                div_load   = 1'b1;
                div_load_d = 32'(abs_rx);
                div_load_n = DELTA_NUM;
            end
            S_DIVX: begin
                if (r_div_cnt == 6'd0) begin
                    div_load   = 1'b1;
                    div_load_d = 32'(abs_ry);
                    div_load_n = DELTA_NUM;
                end
            end
            S_SIDEX: begin
                mul_a = {1'b0, r_dx};
                mul_b = {2'b00, fx_term};
            end
            S_SIDEY: begin
                mul_a = {1'b0, r_dy};
                mul_b = {2'b00, fy_term};
            end
            S_WREAD: begin
                if (walk_stop) begin
                    div_load   = 1'b1;
                    div_load_d = perp_now;
                    div_load_n = LH_NUM;
                end
            end
            S_DIVLH: begin
                if (r_div_cnt == 6'd0) begin
                    div_load   = 1'b1;
                    div_load_d = 32'(lh_next);
                    div_load_n = STEP_NUM;
                end
            end
            S_WALL: begin
                mul_a = {1'b0, r_perp};
                mul_b = r_side ? r_rx : r_ry;
            end
            S_TSTART: begin
                mul_a = {10'd0, r_step};
                mul_b = {4'd0, off};
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall = in_stall;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_dir_x     <= '0;
            r_dir_y     <= '0;
            r_plane_x   <= '0;
            r_plane_y   <= '0;
            r_grid_w    <= 7'd64;
            r_grid_h    <= 7'd64;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POS_X:   r_pos_x   <= i_cfg_data;
                    CFG_POS_Y:   r_pos_y   <= i_cfg_data;
                    CFG_DIR_X:   r_dir_x   <= i_cfg_data[17:0];
                    CFG_DIR_Y:   r_dir_y   <= i_cfg_data[17:0];
                    CFG_PLANE_X: r_plane_x <= i_cfg_data[17:0];
                    CFG_PLANE_Y: r_plane_y <= i_cfg_data[17:0];
                    CFG_GRID_W:  r_grid_w  <= i_cfg_data[6:0];
                    CFG_GRID_H:  r_grid_h  <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
            if (div_load) begin
                r_div_cnt <= DIV_STEPS;
            end else if (r_div_cnt != 6'd0) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (div_load) begin
            r_div_rem <= '0;
            r_div_quo <= div_load_n;
            r_div_d   <= div_load_d;
        end else if (r_div_cnt != 6'd0) begin
            r_div_rem <= div_ge ? div_diff[31:0] : div_sh[31:0];
            r_div_quo <= {r_div_quo[31:0], div_ge};
        end

        case (r_state)
            S_IDLE:  r_col <= i_screen_column;
            S_RAYY:  r_rx  <= {r_dir_x[17], r_dir_x} + r_prod[34:16];
            S_RAYD:  r_ry  <= {r_dir_y[17], r_dir_y} + r_prod[34:16];
            S_DIVX:  if (r_div_cnt == 6'd0) r_dx <= div_q_sat;
            S_DIVY:  if (r_div_cnt == 6'd0) r_dy <= div_q_sat;
            S_SIDEY: r_sx <= (|r_prod[51:48]) ? DIST_MAX : r_prod[47:16];
            S_SIDED: begin
                r_sy <= (|r_prod[51:48]) ? DIST_MAX : r_prod[47:16];
                r_mx <= {2'b00, r_pos_x[21:16]};
                r_my <= {2'b00, r_pos_y[21:16]};
            end
            S_WSTEP: begin
                if (step_x) begin
                    r_sx   <= sx_add[32] ? DIST_MAX : sx_add[31:0];
                    r_mx   <= mx_next;
                    r_side <= 1'b0;
                end else begin
                    r_sy   <= sy_add[32] ? DIST_MAX : sy_add[31:0];
                    r_my   <= my_next;
                    r_side <= 1'b1;
                end
            end
            S_WREAD: r_perp <= perp_now;
            S_DIVLH: if (r_div_cnt == 6'd0) r_lh <= lh_next;
            S_DIVST: if (r_div_cnt == 6'd0) r_step <= step_next;
            S_TSTART: r_tex <= mirror ? (6'(TEXTURE_SIZE - 1) - tex_raw) : tex_raw;
            S_TSTARTD: begin
                r_tstart <= ($unsigned(r_prod) > 52'(OUT_SAT)) ? OUT_SAT : r_prod[22:0];
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_col    <= r_col;
                    r_out_side   <= r_side;
                    r_out_tidx   <= tidx;
                    r_out_tex    <= r_tex;
                    r_out_lh     <= r_lh;
                    r_out_ds     <= ds;
                    r_out_de     <= de;
                    r_out_step   <= r_step;
                    r_out_tstart <= r_tstart;
                end
            end
            default: begin
            end
        endcase
    end

    gdda_ram #(
        .WIDTH(1),
        .DEPTH(MAP_DEPTH)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_out_valid      = r_out_valid;
    assign o_column_out     = r_out_col;
    assign o_hit_side       = r_out_side;
    assign o_texture_index  = r_out_tidx;
    assign o_texture_column = r_out_tex;
    assign o_line_height    = r_out_lh;
    assign o_draw_start     = r_out_ds;
    assign o_draw_end       = r_out_de;
    assign o_texture_step   = r_out_step;
    assign o_texture_start  = r_out_tstart;

    // ---------------- assertions ----------------
    `GDDA_ASSERT(a_cast_starts, i_clk, i_rst_n, in_accept && i_op == OP_CAST |=> r_state == S_RAYX, "cast transfer did not start the ray setup")
    `GDDA_ASSERT(a_delta_x_done, i_clk, i_rst_n, r_state == S_DIVX && r_div_cnt == 6'd0 |=> r_state == S_DIVY && r_div_cnt == DIV_STEPS, "x delta division did not hand over to y")
    `GDDA_ASSERT(a_walk_dist, i_clk, i_rst_n, r_state == S_WREAD |-> (r_side ? (r_sy >= r_dy) : (r_sx >= r_dx)), "side distance below its delta after a step")
    `GDDA_ASSERT_ALWAYS(a_clear_blocks, i_clk, r_state == S_CLEAR |-> o_in_stall, "input open during map clearing")

endmodule
